>>> sv/value_noise_3d_assert.svh
// Assertion macros for the noise block checker
`ifndef VALUE_NOISE_3D_ASSERT_SVH
`define VALUE_NOISE_3D_ASSERT_SVH

// Assert an implication, reset-qualified
`define VN_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Assert an implication whose consequent must hold in the next cycle
`define VN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/vn3d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn3d_pkg
// Constants shared by the value noise block.
// ----------------------------------------------------------------------------
package vn3d_pkg;
	localparam int LATTICE_BITS_DEF = 8;
	localparam int FRAC_W           = 16;
	localparam int VAL_W            = 18;
	localparam int LATENCY          = 12;
	localparam logic [31:0] H_Y     = 32'd57;
	localparam logic [31:0] H_Z     = 32'd997;
	localparam logic [31:0] H_C1    = 32'd15731;
	localparam logic [31:0] H_C2    = 32'd789221;
	localparam logic [31:0] H_C3    = 32'd1376312589;
	localparam logic [17:0] ONE_Q16 = 18'd65536;
endpackage

>>> sv/value_noise_3d.sv
`timescale 1ns / 1ps
// done is the start beat carried through the vld_q shift register, in step with stages s1 to s12.
// Throughput: one point per cycle; busy is never raised, the pipeline
// advances every cycle since the receiver cannot stall.
// Reset: arst_n clears every stage valid bit; payload is not reset.
// ----------------------------------------------------------------------------
// value_noise_3d
// Trilinear 3D lattice value noise with smoothstep easing, Q16.16 in, Q.16 out.
// ----------------------------------------------------------------------------
module value_noise_3d
	import vn3d_pkg::*;
#(
	parameter int LATTICE_BITS = LATTICE_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic signed [31:0]      coord_x,
	input  logic signed [31:0]      coord_y,
	input  logic signed [31:0]      coord_z,
	output logic                    done,
	output logic signed [VAL_W-1:0] noise_value
);
	localparam int IW = LATTICE_BITS + 1;

	logic [LATENCY:1] vld_q;
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LATENCY-1:1], start};
		end
	end

	// ---------------- s1: capture integer and fraction parts, f*f
	logic [IW-1:0] xi_s1, yi_s1, zi_s1;
	logic [15:0]   f_s1 [3];
	logic [31:0]   f2_s1 [3];
	always_ff @(posedge clk) begin
		xi_s1 <= IW'(coord_x[16 +: LATTICE_BITS]);
		yi_s1 <= IW'(coord_y[16 +: LATTICE_BITS]);
		zi_s1 <= IW'(coord_z[16 +: LATTICE_BITS]);
		f_s1[0] <= coord_x[15:0];
		f_s1[1] <= coord_y[15:0];
		f_s1[2] <= coord_z[15:0];
		f2_s1[0] <= 32'(coord_x[15:0]) * 32'(coord_x[15:0]);
		f2_s1[1] <= 32'(coord_y[15:0]) * 32'(coord_y[15:0]);
		f2_s1[2] <= 32'(coord_z[15:0]) * 32'(coord_z[15:0]);
	end

	// ---------------- s2: corner n sums, ease product
	logic [31:0] n_s2 [8];
	logic [15:0] e_s2 [3];
	always_ff @(posedge clk) begin
		for (int k = 0; k < 8; k++) begin
			n_s2[k] <= 32'(xi_s1 + IW'(k & 1)) + 32'(yi_s1 + IW'((k >> 1) & 1)) * H_Y
				+ 32'(zi_s1 + IW'((k >> 2) & 1)) * H_Z;
		end
		for (int a = 0; a < 3; a++) begin
			e_s2[a] <= 16'((34'(f2_s1[a][31:16]) * (34'(196608) - 34'({f_s1[a], 1'b0}))) >> 16);
		end
	end

	// ---------------- s3: xor-shift
	logic [31:0] n_s3 [8];
	always_ff @(posedge clk) begin
		for (int k = 0; k < 8; k++) n_s3[k] <= (n_s2[k] << 13) ^ n_s2[k];
	end

	// ---------------- s4: n*n ; s5: *C1 + C2 ; s6: n*() + C3 ; s7: map
	logic [31:0] n_s4 [8], sq_s4 [8], n_s5 [8], p_s5 [8], m_s6 [8];
	logic signed [VAL_W-1:0] c_s7 [8];
	always_ff @(posedge clk) begin
		for (int k = 0; k < 8; k++) begin
			n_s4[k]  <= n_s3[k];
			sq_s4[k] <= n_s3[k] * n_s3[k];
			n_s5[k]  <= n_s4[k];
			p_s5[k]  <= sq_s4[k] * H_C1 + H_C2;
			m_s6[k]  <= n_s5[k] * p_s5[k] + H_C3;
			c_s7[k]  <= $signed(ONE_Q16 - 18'(m_s6[k][30:14]));
		end
	end

	// ease values travel alongside
	logic [15:0] e_s3 [3], e_s4 [3], e_s5 [3], e_s6 [3], e_s7 [3];
	always_ff @(posedge clk) begin
		e_s3 <= e_s2; e_s4 <= e_s3; e_s5 <= e_s4; e_s6 <= e_s5; e_s7 <= e_s6;
	end

	function automatic logic signed [VAL_W+16:0] lprod(input logic signed [VAL_W-1:0] a,
		input logic signed [VAL_W-1:0] b, input logic [15:0] t);
		logic signed [VAL_W:0] d;
		d = VAL_W'(0) + ((VAL_W+1)'(b) - (VAL_W+1)'(a));
		return (VAL_W+17)'($signed({1'b0, t}) * d);
	endfunction

	// ---------------- s8/s9: x lerps (product, then add)
	logic signed [VAL_W+16:0] px_s8 [4];
	logic signed [VAL_W-1:0]  lo_s8 [4], x_s9 [4];
	logic [15:0] e_s8 [2], e_s9 [2];
	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			px_s8[k] <= lprod(c_s7[2*k], c_s7[2*k+1], e_s7[0]);
			lo_s8[k] <= c_s7[2*k];
			x_s9[k]  <= lo_s8[k] + VAL_W'(px_s8[k] >>> 16);
		end
		e_s8 <= e_s7[1:2]; e_s9 <= e_s8;
	end

	// ---------------- s10/s11: y lerps
	logic signed [VAL_W+16:0] py_s10 [2];
	logic signed [VAL_W-1:0]  ly_s10 [2], y_s11 [2];
	logic [15:0] w_s10, w_s11;
	always_ff @(posedge clk) begin
		for (int k = 0; k < 2; k++) begin
			py_s10[k] <= lprod(x_s9[2*k], x_s9[2*k+1], e_s9[0]);
			ly_s10[k] <= x_s9[2*k];
			y_s11[k]  <= ly_s10[k] + VAL_W'(py_s10[k] >>> 16);
		end
		w_s10 <= e_s9[1]; w_s11 <= w_s10;
	end

	// ---------------- s12: z lerp (narrow, product and add in one stage)
	logic signed [VAL_W+16:0] pz;
	logic signed [VAL_W-1:0]  r_s12;
	assign pz = lprod(y_s11[0], y_s11[1], w_s11);
	always_ff @(posedge clk) r_s12 <= y_s11[0] + VAL_W'(pz >>> 16);

	assign done        = vld_q[LATENCY];
	assign noise_value = r_s12;
endmodule

>>> sv/vn3d_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn3d_checker
// Port-level checks on the noise block.
// ----------------------------------------------------------------------------
`include "value_noise_3d_assert.svh"
module vn3d_checker
	import vn3d_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    start,
	input logic                    busy,
	input logic                    done,
	input logic signed [VAL_W-1:0] noise_value
);
	`VN_ASSERT_IMP(a_never_busy, clk, arst_n, 1'b1, !busy, "busy raised")
	`VN_ASSERT_IMP(a_done_follows, clk, arst_n, done, $past(start, LATENCY), "done without beat")
	`VN_ASSERT_IMP(a_range, clk, arst_n, done, (noise_value <= 18'sd65536) && (noise_value >= -18'sd65536), "out of range")
endmodule

bind value_noise_3d vn3d_checker u_vn3d_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.done(done), .noise_value(noise_value)
);
